[hdl/afrc_pkg.sv]
// Shared package of the ASCII frame reply checker: frame geometry, character
// codes, status and sequencer state types, and the memory request and result
// word structures. No dependencies.
`default_nettype none

package afrc_pkg;

  // Frame geometry
  localparam int FRAME_MAX   = 48;
  localparam int FRAME_MIN   = 18;
  localparam int HEAD_LEN    = 14;
  localparam int PAYLOAD_MAX = 30;

  // Widths derived from the store depth and the payload maximum
  localparam int ADDR_W = $clog2(FRAME_MAX);
  localparam int CNT_W  = $clog2(FRAME_MAX + 1);
  localparam int LEN_W  = $clog2(PAYLOAD_MAX + 1);

  // Character codes
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;

  // Configuration register indexes
  localparam logic CFG_EXPECTED_ID   = 1'b0;
  localparam logic CFG_EXPECTED_FUNC = 1'b1;

  typedef enum logic [2:0] {
    STAT_OK            = 3'd0,
    STAT_OVERFLOW      = 3'd1,
    STAT_NO_START      = 3'd2,
    STAT_BAD_CHECKSUM  = 3'd3,
    STAT_ID_MISMATCH   = 3'd4,
    STAT_FUNC_MISMATCH = 3'd5,
    STAT_BAD_LENGTH    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PASS,
    S_JUDGE,
    S_EMIT_RD,
    S_EMIT_DATA,
    S_STATUS
  } state_t;

  // Request to the frame store
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

  // One result word
  typedef struct packed {
    logic       is_status;
    logic [7:0] payload_byte;
    status_t    status;
    logic       last;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic hex_ok(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE], [CH_UC_A:CH_UC_F], [CH_LC_A:CH_LC_F]};
  endfunction

  // Digits map through the low nibble; letters of either case add nine to it.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return is_digit(c) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

endpackage

`default_nettype wire

[hdl/afrc_frame_store.sv]
// Frame store of the reply checker: one write port, one read port with a
// registered read word that holds while no read is issued. Uses afrc_pkg.
`default_nettype none

module afrc_frame_store (
  input  wire logic               clk,
  input  wire afrc_pkg::ram_req_t req,
  output logic [7:0]              rd_data
);

  logic [7:0] mem [afrc_pkg::FRAME_MAX];
  logic [7:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[hdl/afrc_out_reg.sv]
// Output register of the reply checker: holds one result word towards the
// receiver and reports when a new word can be loaded. Uses afrc_pkg.
`default_nettype none

module afrc_out_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           ld_valid,
  input  wire afrc_pkg::res_t ld_word,
  output logic                ld_free,
  output logic                out_valid,
  input  wire logic           out_stall,
  output afrc_pkg::res_t      out_word
);

  logic           valid_r;
  logic           valid_nxt;
  afrc_pkg::res_t word_r;

  // Free when empty or when the held word leaves at this edge.
  assign ld_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (ld_valid && ld_free) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk) begin
    if (ld_valid && ld_free) begin
      word_r <= ld_word;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

`default_nettype wire

[hdl/afrc_seq.sv]
// Sequencer of the reply checker: stores incoming bytes, scans the store for
// the start mark, runs the check pass and emits the payload and status.
// Uses afrc_pkg.
`default_nettype none

module afrc_seq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_rx_byte,
  input  wire logic [23:0]          exp_id,
  input  wire logic [15:0]          exp_func,
  output afrc_pkg::ram_req_t        ram_req,
  input  wire logic [7:0]           ram_rd_data,
  input  wire logic                 ld_free,
  output logic                      ld_valid,
  output afrc_pkg::res_t            ld_word
);

  localparam int CW = afrc_pkg::CNT_W;
  localparam int AW = afrc_pkg::ADDR_W;
  localparam int LW = afrc_pkg::LEN_W;

  afrc_pkg::state_t  state_r, state_nxt;
  afrc_pkg::status_t stat_r, stat_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic              prev_cr_r, prev_cr_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     s_r, s_nxt;
  logic [CW-1:0]     flen_r, flen_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic              id_ok_r, id_ok_nxt;
  logic              f0_eq_r, f0_eq_nxt;
  logic              f1_eq_r, f1_eq_nxt;
  logic              f1_zero_r, f1_zero_nxt;
  logic [7:0]        l0_r, l0_nxt;
  logic [7:0]        l1_r, l1_nxt;
  logic [7:0]        h1_r, h1_nxt;
  logic [7:0]        h2_r, h2_nxt;
  logic [LW-1:0]     len_r, len_nxt;

  logic              in_fire;
  logic              closing;
  logic              store_full;
  logic [CW-1:0]     cnt_inc;
  logic [CW-1:0]     doff;
  logic [CW-1:0]     scan_s;
  logic [CW-1:0]     scan_flen;
  logic [6:0]        len_dec;
  logic              len_ok;
  logic [7:0]        chk_val;
  logic              chk_ok;
  logic              func_ok;

  assign in_stall = (state_r != afrc_pkg::S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign closing  = prev_cr_r && (in_rx_byte == afrc_pkg::CH_LF);
  assign store_full = (cnt_r == CW'(afrc_pkg::FRAME_MAX));
  assign cnt_inc  = cnt_r + CW'(1);

  // Offset of the byte now on the read port, and candidate start during a scan
  assign doff      = idx_r - CW'(1);
  assign scan_s    = idx_r - CW'(1);
  assign scan_flen = cnt_r - scan_s;

  // Length field decode and the judgement of the collected fields
  assign len_dec = ({3'd0, l0_r[3:0]} << 3) + ({3'd0, l0_r[3:0]} << 1) + {3'd0, l1_r[3:0]};
  assign len_ok  = afrc_pkg::is_digit(l0_r) && afrc_pkg::is_digit(l1_r) &&
                   ({1'b0, len_dec} + 8'(afrc_pkg::FRAME_MIN) == 8'(flen_r)) &&
                   (len_dec <= 7'(afrc_pkg::PAYLOAD_MAX));
  assign chk_val = {afrc_pkg::hex_val(h1_r), afrc_pkg::hex_val(h2_r)};
  assign chk_ok  = afrc_pkg::hex_ok(h1_r) && afrc_pkg::hex_ok(h2_r) && (chk_val == sum_r);
  assign func_ok = f0_eq_r && (f1_eq_r || f1_zero_r);

  // Next state and datapath updates
  always_comb begin
    state_nxt   = state_r;
    stat_nxt    = stat_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    prev_cr_nxt = prev_cr_r;
    idx_nxt     = idx_r;
    pend_nxt    = pend_r;
    s_nxt       = s_r;
    flen_nxt    = flen_r;
    sum_nxt     = sum_r;
    id_ok_nxt   = id_ok_r;
    f0_eq_nxt   = f0_eq_r;
    f1_eq_nxt   = f1_eq_r;
    f1_zero_nxt = f1_zero_r;
    l0_nxt      = l0_r;
    l1_nxt      = l1_r;
    h1_nxt      = h1_r;
    h2_nxt      = h2_r;
    len_nxt     = len_r;
    case (state_r)
      afrc_pkg::S_IDLE: begin
        if (in_fire) begin
          prev_cr_nxt = (in_rx_byte == afrc_pkg::CH_CR);
          if (store_full) begin
            ovf_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_inc;
          end
          if (closing) begin
            if (ovf_r || store_full) begin
              cnt_nxt   = '0;
              ovf_nxt   = 1'b0;
              stat_nxt  = afrc_pkg::STAT_OVERFLOW;
              state_nxt = afrc_pkg::S_STATUS;
            end else if (cnt_inc >= CW'(afrc_pkg::FRAME_MIN)) begin
              idx_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = afrc_pkg::S_SCAN;
            end
          end
        end
      end
      afrc_pkg::S_SCAN: begin
        if (pend_r && ram_rd_data == afrc_pkg::CH_CARET) begin
          // Start mark found: the chunk is consumed whatever the outcome.
          s_nxt    = scan_s[AW-1:0];
          flen_nxt = scan_flen;
          cnt_nxt  = '0;
          if (scan_flen < CW'(afrc_pkg::FRAME_MIN)) begin
            stat_nxt  = afrc_pkg::STAT_BAD_LENGTH;
            state_nxt = afrc_pkg::S_STATUS;
          end else begin
            idx_nxt   = CW'(1);
            pend_nxt  = 1'b0;
            sum_nxt   = '0;
            id_ok_nxt = 1'b1;
            state_nxt = afrc_pkg::S_PASS;
          end
        end else if (pend_r && idx_r == cnt_r) begin
          stat_nxt  = afrc_pkg::STAT_NO_START;
          state_nxt = afrc_pkg::S_STATUS;
        end else begin
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end
      end
      afrc_pkg::S_PASS: begin
        // One byte a cycle from the id through the second checksum character
        if (pend_r) begin
          if (doff == CW'(1)) begin
            id_ok_nxt = id_ok_r && (ram_rd_data == exp_id[23:16]);
          end
          if (doff == CW'(2)) begin
            id_ok_nxt = id_ok_r && (ram_rd_data == exp_id[15:8]);
          end
          if (doff == CW'(3)) begin
            id_ok_nxt = id_ok_r && (ram_rd_data == exp_id[7:0]);
          end
          if (doff == CW'(6)) begin
            f0_eq_nxt = (ram_rd_data == exp_func[15:8]);
          end
          if (doff == CW'(7)) begin
            f1_eq_nxt   = (ram_rd_data == exp_func[7:0]);
            f1_zero_nxt = (ram_rd_data == afrc_pkg::CH_ZERO);
          end
          if (doff == CW'(12)) begin
            l0_nxt = ram_rd_data;
          end
          if (doff == CW'(13)) begin
            l1_nxt = ram_rd_data;
          end
          if (doff <= flen_r - CW'(5)) begin
            sum_nxt = sum_r + ram_rd_data;
          end
          if (doff == flen_r - CW'(4)) begin
            h1_nxt = ram_rd_data;
          end
          if (doff == flen_r - CW'(3)) begin
            h2_nxt    = ram_rd_data;
            state_nxt = afrc_pkg::S_JUDGE;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end else begin
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end
      end
      afrc_pkg::S_JUDGE: begin
        // Checks in order: length, checksum, id, function
        if (!len_ok) begin
          stat_nxt  = afrc_pkg::STAT_BAD_LENGTH;
          state_nxt = afrc_pkg::S_STATUS;
        end else if (!chk_ok) begin
          stat_nxt  = afrc_pkg::STAT_BAD_CHECKSUM;
          state_nxt = afrc_pkg::S_STATUS;
        end else if (!id_ok_r) begin
          stat_nxt  = afrc_pkg::STAT_ID_MISMATCH;
          state_nxt = afrc_pkg::S_STATUS;
        end else if (!func_ok) begin
          stat_nxt  = afrc_pkg::STAT_FUNC_MISMATCH;
          state_nxt = afrc_pkg::S_STATUS;
        end else begin
          stat_nxt = afrc_pkg::STAT_OK;
          len_nxt  = len_dec[LW-1:0];
          idx_nxt  = '0;
          if (len_dec == 7'd0) begin
            state_nxt = afrc_pkg::S_STATUS;
          end else begin
            state_nxt = afrc_pkg::S_EMIT_RD;
          end
        end
      end
      afrc_pkg::S_EMIT_RD: begin
        state_nxt = afrc_pkg::S_EMIT_DATA;
      end
      afrc_pkg::S_EMIT_DATA: begin
        if (ld_free) begin
          if (idx_r == CW'(len_r) - CW'(1)) begin
            state_nxt = afrc_pkg::S_STATUS;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = afrc_pkg::S_EMIT_RD;
          end
        end
      end
      afrc_pkg::S_STATUS: begin
        if (ld_free) begin
          state_nxt = afrc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = afrc_pkg::S_IDLE;
      end
    endcase
  end

  // Memory requests and result words
  always_comb begin
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = cnt_r[AW-1:0];
    ram_req.wr_data = in_rx_byte;
    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = idx_r[AW-1:0];
    ld_valid        = 1'b0;
    ld_word.is_status    = 1'b0;
    ld_word.payload_byte = ram_rd_data;
    ld_word.status       = afrc_pkg::STAT_OK;
    ld_word.last         = 1'b0;
    case (state_r)
      afrc_pkg::S_IDLE: begin
        ram_req.wr_en = in_fire && !store_full;
      end
      afrc_pkg::S_SCAN: begin
        ram_req.rd_en = (idx_r < cnt_r);
      end
      afrc_pkg::S_PASS: begin
        ram_req.rd_en   = (idx_r <= flen_r - CW'(3));
        ram_req.rd_addr = s_r + idx_r[AW-1:0];
      end
      afrc_pkg::S_EMIT_RD: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = s_r + AW'(afrc_pkg::HEAD_LEN) + idx_r[AW-1:0];
      end
      afrc_pkg::S_EMIT_DATA: begin
        ld_valid = 1'b1;
      end
      afrc_pkg::S_STATUS: begin
        ld_valid             = 1'b1;
        ld_word.is_status    = 1'b1;
        ld_word.payload_byte = '0;
        ld_word.status       = stat_r;
        ld_word.last         = 1'b1;
      end
      default: begin
        ld_valid = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= afrc_pkg::S_IDLE;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      prev_cr_r <= 1'b0;
      idx_r     <= '0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      ovf_r     <= ovf_nxt;
      prev_cr_r <= prev_cr_nxt;
      idx_r     <= idx_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    stat_r    <= stat_nxt;
    s_r       <= s_nxt;
    flen_r    <= flen_nxt;
    sum_r     <= sum_nxt;
    id_ok_r   <= id_ok_nxt;
    f0_eq_r   <= f0_eq_nxt;
    f1_eq_r   <= f1_eq_nxt;
    f1_zero_r <= f1_zero_nxt;
    l0_r      <= l0_nxt;
    l1_r      <= l1_nxt;
    h1_r      <= h1_nxt;
    h2_r      <= h2_nxt;
    len_r     <= len_nxt;
  end

endmodule

`default_nettype wire

[hdl/ascii_frame_reply_checker.sv]
// ASCII frame reply checker: receives serial bytes one word at a time and
// reports, when CR LF closes a chunk, the payload and status of the reply.
//
// Channels: in_* carries one received byte per word; out_* carries result
// words, each either a payload byte (out_is_status low) or a status word
// (out_is_status high, out_last high). cfg_* writes the expected board id
// (index 0) and function code (index 1); cfg_ready is always high.
// A byte that does not close a chunk is taken and the next byte can follow
// at once. A closing byte of a chunk that overflowed the store yields an
// overflow status; one that closes a chunk shorter than FRAME_MIN bytes is
// stored like any other. Otherwise it starts a pass over the frame store,
// which has one read port: the scan for the start mark, the check pass from
// the id through the checksum, the judgement, a read and a load for each
// payload byte and then the status word, with in_stall high throughout.
// When the receiver stalls, the output register holds its word and the
// sequencer waits; a waiting final status word does not block the next
// input byte. Reset (rst_n low, synchronous) empties the byte count, the
// overflow and CR flags and the output register; configuration resets to
// zero. The store contents need no clearing.
// Depends on afrc_pkg, afrc_seq, afrc_frame_store and afrc_out_reg.
`default_nettype none

module ascii_frame_reply_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_status,
  output logic [7:0]       out_payload_byte,
  output logic [2:0]       out_status,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data
);

  logic [23:0]        exp_id_r;
  logic [15:0]        exp_func_r;
  afrc_pkg::ram_req_t ram_req;
  logic [7:0]         ram_rd_data;
  logic               ld_free;
  logic               ld_valid;
  afrc_pkg::res_t     ld_word;
  afrc_pkg::res_t     out_word;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_id_r   <= '0;
      exp_func_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        afrc_pkg::CFG_EXPECTED_ID:   exp_id_r   <= cfg_data;
        afrc_pkg::CFG_EXPECTED_FUNC: exp_func_r <= cfg_data[15:0];
        default: begin
          exp_id_r <= exp_id_r;
        end
      endcase
    end
  end

  afrc_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_byte  (in_rx_byte),
    .exp_id      (exp_id_r),
    .exp_func    (exp_func_r),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data),
    .ld_free     (ld_free),
    .ld_valid    (ld_valid),
    .ld_word     (ld_word)
  );

  afrc_frame_store u_store (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  afrc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_valid  (ld_valid),
    .ld_word   (ld_word),
    .ld_free   (ld_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Result word onto its ports
  assign out_is_status    = out_word.is_status;
  assign out_payload_byte = out_word.payload_byte;
  assign out_status       = out_word.status;
  assign out_last         = out_word.last;

endmodule

`default_nettype wire
